[rtl/core/avr_pkg.sv]
// Shared types, widths and tables for the axis-angle vector rotator.
// No dependencies; used by axis_angle_vector_rotate.
package avr_pkg;

    localparam int COORD_WIDTH = 32;   // Q16.16 vector components
    localparam int AXIS_IN_W   = 16;   // Q2.14 axis as delivered
    localparam int AXIS_W      = 17;   // clamped axis, holds +/-1.0
    localparam int ANGLE_W     = 16;
    localparam int CRD_W       = 34;   // CORDIC x/y/z datapath
    localparam int TRIG_W      = 27;   // Q5.22 cosine/sine
    localparam int MAT_W       = 32;   // Q28 matrix term
    localparam int ATAN_N      = 24;
    localparam logic signed [CRD_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [AXIS_W-1:0] AXIS_ONE = 17'sd16384;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vec_x;
        logic signed [COORD_WIDTH-1:0] vec_y;
        logic signed [COORD_WIDTH-1:0] vec_z;
        logic signed [AXIS_IN_W-1:0]   axis_x;
        logic signed [AXIS_IN_W-1:0]   axis_y;
        logic signed [AXIS_IN_W-1:0]   axis_z;
        logic        [ANGLE_W-1:0]     turn_angle;
    } t_avr_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rot_x;
        logic signed [COORD_WIDTH-1:0] rot_y;
        logic signed [COORD_WIDTH-1:0] rot_z;
    } t_avr_out;

    // Vector and clamped axis carried down the pipeline
    typedef struct packed {
        logic signed [2:0][COORD_WIDTH-1:0] vec;
        logic signed [2:0][AXIS_W-1:0]      axis;
    } t_avr_carry;

    // Arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [AXIS_W-1:0] clamp_axis(
        input logic signed [AXIS_IN_W-1:0] a
    );
        logic signed [AXIS_W-1:0] w;
        w = AXIS_W'(a);
        if (w > AXIS_ONE) begin
            w = AXIS_ONE;
        end else if (w < -AXIS_ONE) begin
            w = -AXIS_ONE;
        end
        return w;
    endfunction

endpackage

[rtl/core/axis_angle_vector_rotate.sv]
// Axis-angle (Rodrigues) vector rotator: CORDIC sine/cosine, matrix build, M*v.
// Depends on avr_pkg.
//
// Rotates a Q16.16 vector about a Q2.14 unit axis by a 16-bit binary angle.
// Fully pipelined: one transfer per cycle in and out unless stalled, through an
// input register, one CORDIC micro-rotation per stage, four stages of matrix
// build and multiply, and an output register. The CORDIC stage count sets the
// latency and sine/cosine precision. The axis is clamped to +/-1.0 per
// component but not normalized. Results truncate toward zero and saturate.
// A stall on the output freezes the whole pipeline; o_stall follows it.
module axis_angle_vector_rotate #(
    parameter int TRIG_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  avr_pkg::t_avr_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output avr_pkg::t_avr_out o_data
);

    localparam int CW = avr_pkg::COORD_WIDTH;
    localparam int CRW = avr_pkg::CRD_W;
    localparam int TW = avr_pkg::TRIG_W;
    localparam int MW = avr_pkg::MAT_W;
    localparam int AW = avr_pkg::AXIS_W;
    localparam int PW = CW + MW;          // v * M product
    localparam int SW = PW - 20 + 2;      // sum of three Q24 products
    localparam int RW = 54;               // Q50 matrix accumulation

    logic adv;
    assign adv = !o_valid || !i_stall;
    assign o_stall = !adv;

    // ---------------- CORDIC section ----------------
    logic                           r_vld [0:TRIG_STAGES];
    logic signed [CRW-1:0]          r_x   [0:TRIG_STAGES];
    logic signed [CRW-1:0]          r_y   [0:TRIG_STAGES];
    logic signed [CRW-1:0]          r_z   [0:TRIG_STAGES];
    logic                           r_flip[0:TRIG_STAGES];
    avr_pkg::t_avr_carry            r_cr  [0:TRIG_STAGES];

    logic [1:0]  n_quad;
    logic        n_flip;
    logic [31:0] n_ang;

    always_comb begin
        n_quad = i_data.turn_angle[15:14];
        n_flip = (n_quad == 2'd1) || (n_quad == 2'd2);
        n_ang  = {i_data.turn_angle, 16'd0};
        if (n_flip) begin
            n_ang[31] = ~n_ang[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x[0]         <= avr_pkg::CORDIC_START;
            r_y[0]         <= '0;
            r_z[0]         <= CRW'($signed(n_ang));
            r_flip[0]      <= n_flip;
            r_cr[0].vec[0] <= i_data.vec_x;
            r_cr[0].vec[1] <= i_data.vec_y;
            r_cr[0].vec[2] <= i_data.vec_z;
            r_cr[0].axis[0] <= avr_pkg::clamp_axis(i_data.axis_x);
            r_cr[0].axis[1] <= avr_pkg::clamp_axis(i_data.axis_y);
            r_cr[0].axis[2] <= avr_pkg::clamp_axis(i_data.axis_z);
        end
    end

    for (genvar k = 1; k <= TRIG_STAGES; k++) begin : g_cordic
        logic signed [CRW-1:0] dx, dy, at;
        assign dx = r_y[k-1] >>> (k - 1);
        assign dy = r_x[k-1] >>> (k - 1);
        assign at = CRW'(avr_pkg::atan_turn(5'(k - 1)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_z[k-1][CRW-1]) begin
                    r_x[k] <= r_x[k-1] - dx;
                    r_y[k] <= r_y[k-1] + dy;
                    r_z[k] <= r_z[k-1] - at;
                end else begin
                    r_x[k] <= r_x[k-1] + dx;
                    r_y[k] <= r_y[k-1] - dy;
                    r_z[k] <= r_z[k-1] + at;
                end
                r_flip[k] <= r_flip[k-1];
                r_cr[k]   <= r_cr[k-1];
            end
        end
    end

    // ---------------- P1: round sine/cosine, axis products ----------------
    logic                    r_p1_vld;
    avr_pkg::t_avr_carry     r_p1_cr;
    logic signed [TW-1:0]    r_c, r_s;
    logic signed [2*AW-1:0]  r_aa [3][3];
    logic signed [CRW-1:0]   n_xf, n_yf, n_xr, n_yr;

    always_comb begin
        n_xf = r_flip[TRIG_STAGES] ? -r_x[TRIG_STAGES] : r_x[TRIG_STAGES];
        n_yf = r_flip[TRIG_STAGES] ? -r_y[TRIG_STAGES] : r_y[TRIG_STAGES];
        n_xr = (n_xf + CRW'(128)) >>> 8;
        n_yr = (n_yf + CRW'(128)) >>> 8;
    end

    // element selects of the packed carry arrays are unsigned; re-sign them
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c     <= n_xr[TW-1:0];
            r_s     <= n_yr[TW-1:0];
            r_p1_cr <= r_cr[TRIG_STAGES];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_aa[i][j] <= (2*AW)'($signed(r_cr[TRIG_STAGES].axis[i]))
                                * (2*AW)'($signed(r_cr[TRIG_STAGES].axis[j]));
                end
            end
        end
    end

    // ---------------- P2: scale by (1-c), sine terms ----------------
    logic                    r_p2_vld;
    avr_pkg::t_avr_carry     r_p2_cr;
    logic signed [RW-1:0]    r_t [3][3];
    logic signed [RW-1:0]    r_cd;
    logic signed [AW+TW-1:0] r_as [3];
    logic signed [TW:0]      n_omc;

    assign n_omc = (TW+1)'(1 << 22) - (TW+1)'(r_c);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_cr <= r_p1_cr;
            r_cd    <= RW'(r_c) <<< 28;
            for (int i = 0; i < 3; i++) begin
                r_as[i] <= (AW+TW)'($signed(r_p1_cr.axis[i])) * (AW+TW)'(r_s);
                for (int j = 0; j < 3; j++) begin
                    r_t[i][j] <= RW'(r_aa[i][j]) * RW'(n_omc);
                end
            end
        end
    end

    // ---------------- P3: assemble matrix, floor to Q28 ----------------
    logic                  r_p3_vld;
    avr_pkg::t_avr_carry   r_p3_cr;
    logic signed [MW-1:0]  r_m [3][3];
    logic signed [RW-1:0]  n_raw [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i == j) begin
                    n_raw[i][j] = r_t[i][j] + r_cd;
                end else if ((i == 1 && j == 0) || (i == 0 && j == 2)
                          || (i == 2 && j == 1)) begin
                    n_raw[i][j] = r_t[i][j] + (RW'(r_as[3-i-j]) <<< 14);
                end else begin
                    n_raw[i][j] = r_t[i][j] - (RW'(r_as[3-i-j]) <<< 14);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_cr <= r_p2_cr;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m[i][j] <= n_raw[i][j][RW-1:22];
                end
            end
        end
    end

    // ---------------- P4: v_j * M[i][j] ----------------
    logic                  r_p4_vld;
    logic signed [PW-1:0]  r_p [3][3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= PW'($signed(r_p3_cr.vec[j])) * PW'(r_m[i][j]);
                end
            end
        end
    end

    // ---------------- P5: sum, truncate, saturate ----------------
    logic signed [SW-1:0] n_sum [3];
    logic signed [SW-1:0] n_tr  [3];
    logic signed [CW-1:0] n_rot [3];
    logic signed [SW-1:0] sat_hi, sat_lo;

    assign sat_hi = SW'({1'b0, {(CW-1){1'b1}}});
    assign sat_lo = -sat_hi - SW'(1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SW'(r_p[i][0] >>> 20) + SW'(r_p[i][1] >>> 20)
                     + SW'(r_p[i][2] >>> 20);
            if (n_sum[i][SW-1]) begin
                n_tr[i] = (n_sum[i] + SW'(255)) >>> 8;
            end else begin
                n_tr[i] = n_sum[i] >>> 8;
            end
            if (n_tr[i] > sat_hi) begin
                n_rot[i] = sat_hi[CW-1:0];
            end else if (n_tr[i] < sat_lo) begin
                n_rot[i] = sat_lo[CW-1:0];
            end else begin
                n_rot[i] = n_tr[i][CW-1:0];
            end
        end
    end

    logic r_ovld;
    avr_pkg::t_avr_out r_out;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.rot_x <= n_rot[0];
            r_out.rot_y <= n_rot[1];
            r_out.rot_z <= n_rot[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else if (adv) begin
            r_p1_vld <= r_vld[TRIG_STAGES];
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_ovld   <= r_p4_vld;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // A new result only appears from a valid item in the last stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_p4_vld))
        else $error("output valid without a valid last stage");

    // Frozen pipeline keeps the last-stage valid in place
    a_hold_p4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_p4_vld))
        else $error("pipeline moved during output stall");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for axis_angle_vector_rotate: directed table, then random transfers.
// Depends on avr_pkg and the rotator RTL; a fixed-point model predicts all but the zero-vector rows.
module tb_top;
    import avr_pkg::*;

    localparam int  STAGES     = 16;
    localparam int  LATENCY    = STAGES + 6;
    localparam int  N_RANDOM   = 1300;
    localparam int  HOLD_LEN   = 300;
    localparam longint LIMIT   = 400000;
    localparam logic signed [15:0] UNIT = 16'sd16384;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_avr_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_avr_out o_data;

    axis_angle_vector_rotate #(.TRIG_STAGES(STAGES)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #1 i_clk = ~i_clk;

    t_avr_out rotated_q[$];
    longint   cycles = 0;
    int       mismatches = 0;
    int       results_seen = 0;
    int       items_sent = 0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;

    // arctangent of 2^-i, 2^-32 turn units
    longint atan_lut[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    function automatic longint q24_product(longint v, longint m);
        longint hi;
        longint lo;
        hi = v >>> 24;
        lo = v - hi * 64'sd16777216;
        return hi * m * 16 + ((lo * m) >>> 20);
    endfunction

    function automatic logic [31:0] to_q16(longint sum24);
        longint v;
        v = (sum24 >= 0) ? (sum24 >>> 8) : -((-sum24) >>> 8);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint clip_axis(logic signed [15:0] a);
        longint w;
        w = longint'(a);
        if (w > 16384) w = 16384;
        if (w < -16384) w = -16384;
        return w;
    endfunction

    function automatic t_avr_out rotate_vec(t_avr_in d);
        logic [31:0] ang;
        bit          flip;
        longint      x, y, z, dx, dy, c, s, omc, ks;
        longint      v[3];
        longint      a[3];
        longint      m[3][3];
        longint      sum[3];
        t_avr_out    r;
        ang  = {d.turn_angle, 16'h0000};
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang = ang + 32'h8000_0000;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_lut[i];
            end else begin
                x += dx; y -= dy; z += atan_lut[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + 128) >>> 8;
        s = (y + 128) >>> 8;
        v[0] = longint'($signed(d.vec_x));
        v[1] = longint'($signed(d.vec_y));
        v[2] = longint'($signed(d.vec_z));
        a[0] = clip_axis(d.axis_x);
        a[1] = clip_axis(d.axis_y);
        a[2] = clip_axis(d.axis_z);
        omc = 64'sd4194304 - c;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = a[i] * a[j] * omc + ((i == j) ? (c <<< 28) : 0);
            end
        end
        ks = s * 16384;
        m[0][1] -= a[2] * ks; m[1][0] += a[2] * ks;
        m[0][2] += a[1] * ks; m[2][0] -= a[1] * ks;
        m[1][2] -= a[0] * ks; m[2][1] += a[0] * ks;
        for (int i = 0; i < 3; i++) begin
            sum[i] = 0;
            for (int j = 0; j < 3; j++) begin
                sum[i] += q24_product(v[j], m[i][j] >>> 22);
            end
        end
        r.rot_x = to_q16(sum[0]);
        r.rot_y = to_q16(sum[1]);
        r.rot_z = to_q16(sum[2]);
        return r;
    endfunction

    function automatic t_avr_in pack_item(longint vx, longint vy, longint vz,
                                          logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] az, logic [15:0] ang);
        t_avr_in d;
        d.vec_x = vx[31:0]; d.vec_y = vy[31:0]; d.vec_z = vz[31:0];
        d.axis_x = ax; d.axis_y = ay; d.axis_z = az;
        d.turn_angle = ang;
        return d;
    endfunction

    // one transfer; the expectation is queued at the accepting edge
    task automatic send_vec(t_avr_in d, bit fixed, t_avr_out fixed_out);
        int gap;
        if (!calm && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        rotated_q.push_back(fixed ? fixed_out : rotate_vec(d));
        items_sent++;
    endtask

    function automatic logic [15:0] rand_axis();
        int k;
        logic [15:0] u;
        k = $urandom_range(9);
        if (k < 3) begin
            u = $urandom_range(1) ? UNIT : -UNIT;
            return (k == 0) ? u : 16'h0000;
        end
        if (k < 7) return 16'($signed($urandom_range(32768)) - 16384);
        return 16'($urandom);
    endfunction

    function automatic longint rand_coord();
        int k;
        k = $urandom_range(9);
        if (k < 4) return longint'($signed(32'($urandom)));
        if (k < 8) return longint'($signed($urandom_range(2000000))) - 1000000;
        case ($urandom_range(3))
            0: return 64'sd2147483647;
            1: return -64'sd2147483648;
            2: return 0;
            default: return longint'($signed($urandom_range(131072))) - 65536;
        endcase
    endfunction

    typedef struct {
        t_avr_in  din;
        bit       fixed;
        t_avr_out dout;
    } t_row;

    // receive side stall
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 19);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_avr_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (rotated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", o_data);
            end else begin
                want = rotated_q.pop_front();
                if (o_data.rot_x !== want.rot_x || o_data.rot_y !== want.rot_y ||
                    o_data.rot_z !== want.rot_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected (%0d %0d %0d) got (%0d %0d %0d)",
                                 results_seen, want.rot_x, want.rot_y, want.rot_z,
                                 o_data.rot_x, o_data.rot_y, o_data.rot_z);
                end
            end
        end
    end

    initial begin
        t_row     rows[$];
        t_row     row;
        t_avr_out zero_out;
        t_avr_in  d;
        int       k;
        zero_out = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector always rotates to zero
        rows.push_back('{pack_item(0, 0, 0, UNIT, 0, 0, 16'h4000), 1, zero_out});
        rows.push_back('{pack_item(0, 0, 0, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF), 1,
                         zero_out});
        // quadrant boundaries and identity angle
        rows.push_back('{pack_item(65536, 0, 0, 0, 0, UNIT, 16'h0000), 0, zero_out});
        rows.push_back('{pack_item(65536, 0, 0, 0, 0, UNIT, 16'h4000), 0, zero_out});
        rows.push_back('{pack_item(65536, 0, 0, 0, 0, UNIT, 16'h8000), 0, zero_out});
        rows.push_back('{pack_item(65536, 0, 0, 0, 0, UNIT, 16'hC000), 0, zero_out});
        rows.push_back('{pack_item(0, 65536, 0, UNIT, 0, 0, 16'h3FFF), 0, zero_out});
        rows.push_back('{pack_item(0, 0, 65536, -UNIT, 0, 0, 16'h7FFF), 0, zero_out});
        rows.push_back('{pack_item(0, 0, 65536, 0, -UNIT, 0, 16'h8001), 0, zero_out});
        // saturation at both ends
        rows.push_back('{pack_item(2147483647, 2147483647, 2147483647, UNIT, UNIT, UNIT,
                                   16'h1000), 0, zero_out});
        rows.push_back('{pack_item(-2147483648, -2147483648, -2147483648, UNIT, UNIT, UNIT,
                                   16'h9000), 0, zero_out});
        rows.push_back('{pack_item(2147483647, -2147483648, 2147483647, -UNIT, UNIT, -UNIT,
                                   16'h6000), 0, zero_out});
        // axis components beyond one get clamped
        rows.push_back('{pack_item(123456, -654321, 777, 16'h7FFF, 16'h8000, 16'h4001,
                                   16'h2345), 0, zero_out});
        rows.push_back('{pack_item(-1, 1, -1, 16'h8000, 16'h7FFF, 16'hBFFF, 16'hE000), 0,
                         zero_out});
        // non-unit axis, negative truncation toward zero
        rows.push_back('{pack_item(-3, 5, -7, 16'h2000, 16'h2000, 0, 16'h5555), 0,
                         zero_out});
        rows.push_back('{pack_item(100000, -100000, 50000, 0, 0, 0, 16'hAAAA), 0,
                         zero_out});
        foreach (rows[n]) begin
            row = rows[n];
            send_vec(row.din, row.fixed, row.dout);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_req = 1'b1;
            if (n == 500) calm = 1'b1;
            if (n == 800) begin
                calm = 1'b0;
                i_valid <= 1'b0;
                wait (rotated_q.size() == 0);
                @(posedge i_clk);
            end
            d = pack_item(rand_coord(), rand_coord(), rand_coord(),
                          rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
            k = $urandom_range(15);
            if (k == 0) d.turn_angle = {2'($urandom), 14'h0000};
            if (k == 1) d.turn_angle = {2'($urandom), 14'h3FFF};
            send_vec(d, 1'b0, zero_out);
        end
        i_valid <= 1'b0;

        wait (rotated_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (rotated_q.size() != 0) mismatches++;
        $display("Rotated %0d vectors (%0d results checked), including a %0d-cycle output",
                 items_sent, results_seen, HOLD_LEN);
        $display("hold-off, a drain pause, clamped axes and saturating extremes.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
